@@ rtl/cll_pkg.sv @@
package cll_pkg;

  localparam int unsigned CapacityDefault = 128;

  typedef enum logic [2:0] {
    KIND_APPEND = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_REMOVE = 3'd2,
    KIND_DELETE = 3'd3,
    KIND_READ   = 3'd4,
    KIND_SEARCH = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECIDE,
    S_POP_RD,
    S_POP_EV,
    S_WALK_RD,
    S_WALK_EV,
    S_FIX,
    S_LINK_A,
    S_LINK_B,
    S_DONE
  } state_e;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT_STEP,
    OP_LOAD,
    OP_DECIDE,
    OP_POP_READ,
    OP_POP_LATCH,
    OP_READ_CUR,
    OP_EVAL,
    OP_FIX,
    OP_LINK_A,
    OP_LINK_B,
    OP_FINISH
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic init_done;
    logic settled;     // request answered from counts and list pointers alone
    logic is_insert;   // request takes a node from the free list
    logic no_walk;     // new node goes to the head
    logic walk_done;   // walk finished at this evaluation
    logic fix_req;     // deleted node had a kept predecessor
    logic has_link;    // walk result needs link writes
  } sts_t;

endpackage

@@ rtl/cll_ctrl.sv @@
module cll_ctrl
  import cll_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT:    if (sts_i.init_done) state_d = S_IDLE;
      S_IDLE:    if (in_valid_i) state_d = S_DECIDE;
      S_DECIDE: begin
        if (sts_i.settled) state_d = S_DONE;
        else if (sts_i.is_insert) state_d = S_POP_RD;
        else state_d = S_WALK_RD;
      end
      S_POP_RD:  state_d = S_POP_EV;
      S_POP_EV: begin
        if (sts_i.no_walk) state_d = S_LINK_B;
        else state_d = S_WALK_RD;
      end
      S_WALK_RD: state_d = S_WALK_EV;
      S_WALK_EV: begin
        if (sts_i.fix_req) state_d = S_FIX;
        else if (sts_i.walk_done) state_d = sts_i.has_link ? S_LINK_A : S_DONE;
        else state_d = S_WALK_RD;
      end
      S_FIX: begin
        if (sts_i.walk_done) state_d = S_DONE;
        else state_d = S_WALK_RD;
      end
      S_LINK_A:  state_d = S_LINK_B;
      S_LINK_B:  state_d = S_DONE;
      S_DONE:    if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op    = OP_NONE;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_INIT:    cmd_o.op = OP_INIT_STEP;
      S_IDLE:    if (in_valid_i) cmd_o.op = OP_LOAD;
      S_DECIDE:  cmd_o.op = OP_DECIDE;
      S_POP_RD:  cmd_o.op = OP_POP_READ;
      S_POP_EV:  cmd_o.op = OP_POP_LATCH;
      S_WALK_RD: cmd_o.op = OP_READ_CUR;
      S_WALK_EV: cmd_o.op = OP_EVAL;
      S_FIX:     cmd_o.op = OP_FIX;
      S_LINK_A:  cmd_o.op = OP_LINK_A;
      S_LINK_B:  cmd_o.op = OP_LINK_B;
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op    = OP_FINISH;
          out_valid_d = 1'b1;
        end
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/cll_dp.sv @@
module cll_dp
  import cll_pkg::*;
#(
  parameter int unsigned Capacity = CapacityDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic [2:0]          kind_i,
  input  logic [7:0]          position_i,
  input  logic signed [31:0]  item_key_i,
  input  logic [31:0]         item_payload_i,
  output logic [1:0]          status_o,
  output logic signed [31:0]  found_key_o,
  output logic [31:0]         found_payload_o,
  output logic [7:0]          length_o,
  output logic [7:0]          removed_count_o
);

  localparam int unsigned IW = $clog2(Capacity + 1);
  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned CW = ((IW > 8) ? IW : 8) + 1;
  localparam logic [IW-1:0] Nil = IW'(Capacity);
  localparam logic [CW-1:0] CapExt = CW'(Capacity);

  // Node store: key, payload and link per node.
  logic [31:0]   key_mem [Capacity];
  logic [31:0]   pay_mem [Capacity];
  logic [IW-1:0] nxt_mem [Capacity];

  logic [IW-1:0] head_q, head_d, free_q, free_d, count_q, count_d;
  logic [IW-1:0] init_q;
  logic [2:0]    kind_q;
  logic [7:0]    pos_q;
  logic [31:0]   key_q, pay_q;
  logic [IW-1:0] cur_q, cur_d, prev_q, prev_d, step_q, step_d;
  logic [IW-1:0] succ_q, succ_d, fnext_q, fnext_d, rem_q, rem_d;
  status_e       st_q, st_d;
  logic [31:0]   fkey_q, fkey_d, fpay_q, fpay_d;
  logic          end_q;
  logic [31:0]   rkey_q, rpay_q;
  logic [IW-1:0] rnxt_q, rnxt_c;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en, kp_en;
  logic [AW-1:0] wr_addr;
  logic [IW-1:0] wr_data;
  logic          settled, is_ins, no_walk, hit, ev_done;
  status_e       st_dec;
  logic [CW-1:0] cnt_ext, pos_ext, step_ext, visited, target;

  assign cnt_ext  = CW'(count_q);
  assign pos_ext  = CW'(pos_q);
  assign step_ext = CW'(step_q);
  assign visited  = step_ext + 1'b1;
  assign rnxt_c   = (rnxt_q < Nil) ? rnxt_q : Nil;
  assign hit      = (rkey_q == key_q);
  assign no_walk  = (kind_q == KIND_INSERT && pos_q == 8'd1) || (head_q >= Nil);

  // Classify the request from counts and list pointers alone.
  always_comb begin
    settled = 1'b1;
    st_dec  = ST_OK;
    is_ins  = 1'b0;
    unique case (kind_q)
      KIND_APPEND, KIND_INSERT: begin
        if (cnt_ext >= CapExt) st_dec = ST_FULL;
        else if (kind_q == KIND_INSERT &&
                 (pos_ext == '0 || pos_ext > cnt_ext + 1'b1)) st_dec = ST_RANGE;
        else if (free_q >= Nil) st_dec = ST_FULL;
        else begin
          settled = 1'b0;
          is_ins  = 1'b1;
        end
      end
      KIND_REMOVE, KIND_READ: begin
        if (count_q == '0) st_dec = ST_EMPTY;
        else if (pos_ext == '0 || pos_ext > cnt_ext) st_dec = ST_RANGE;
        else settled = 1'b0;
      end
      KIND_DELETE: begin
        st_dec = ST_EMPTY;
        if (head_q < Nil) settled = 1'b0;
      end
      KIND_SEARCH: begin
        st_dec = ST_EMPTY;
        if (head_q < Nil && count_q != '0) settled = 1'b0;
      end
      default: st_dec = ST_RANGE;
    endcase
  end

  // Insert walks to the node before the position, remove and read to the node at it.
  always_comb begin
    unique case (kind_q)
      KIND_APPEND:            target = cnt_ext;
      KIND_INSERT:            target = pos_ext - 1'b1;
      KIND_REMOVE, KIND_READ: target = pos_ext;
      default:                target = '0;
    endcase
  end

  always_comb begin
    unique case (kind_q)
      KIND_DELETE: ev_done = (rnxt_c == Nil) || (visited >= CapExt);
      KIND_SEARCH: ev_done = hit || (rnxt_c == Nil) || (visited >= cnt_ext) ||
                             (visited >= CapExt);
      default:     ev_done = (visited >= target) || (rnxt_c == Nil);
    endcase
  end

  assign sts_o.init_done = (init_q == Nil - 1'b1);
  assign sts_o.settled   = settled;
  assign sts_o.is_insert = is_ins;
  assign sts_o.no_walk   = no_walk;
  assign sts_o.walk_done = (cmd_i.op == OP_FIX) ? end_q : ev_done;
  assign sts_o.fix_req   = (kind_q == KIND_DELETE) && hit && (prev_q != Nil);
  assign sts_o.has_link  = (kind_q == KIND_APPEND) || (kind_q == KIND_INSERT) ||
                           (kind_q == KIND_REMOVE);

  // Next state of the list registers and the single link write port.
  always_comb begin
    wr_en   = 1'b0;
    kp_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    head_d  = head_q;
    free_d  = free_q;
    count_d = count_q;
    cur_d   = cur_q;
    prev_d  = prev_q;
    step_d  = step_q;
    succ_d  = succ_q;
    fnext_d = fnext_q;
    rem_d   = rem_q;
    st_d    = st_q;
    fkey_d  = fkey_q;
    fpay_d  = fpay_q;
    unique case (cmd_i.op)
      OP_INIT_STEP: begin
        wr_en   = 1'b1;
        wr_addr = AW'(init_q);
        wr_data = init_q + 1'b1;
      end
      OP_LOAD: begin
        cur_d  = head_q;
        prev_d = Nil;
        step_d = '0;
        rem_d  = '0;
        fkey_d = '0;
        fpay_d = '0;
        st_d   = ST_OK;
      end
      OP_DECIDE:    st_d = st_dec;
      OP_POP_LATCH: fnext_d = rnxt_c;
      OP_EVAL: begin
        unique case (kind_q)
          KIND_DELETE: begin
            cur_d  = rnxt_c;
            step_d = step_q + 1'b1;
            if (hit) begin
              // Push the matching node on the free list; a kept predecessor is fixed next.
              wr_en   = 1'b1;
              wr_addr = AW'(cur_q);
              wr_data = free_q;
              free_d  = cur_q;
              if (prev_q == Nil) head_d = rnxt_c;
              if (count_q != '0) count_d = count_q - 1'b1;
              rem_d = rem_q + 1'b1;
            end else begin
              prev_d = cur_q;
            end
            if (ev_done) st_d = (rem_q == '0 && !hit) ? ST_EMPTY : ST_OK;
          end
          KIND_SEARCH: begin
            cur_d  = rnxt_c;
            step_d = step_q + 1'b1;
            if (hit) begin
              st_d   = ST_OK;
              fkey_d = rkey_q;
              fpay_d = rpay_q;
            end
          end
          default: begin
            if (ev_done) begin
              succ_d = rnxt_c;
              if (kind_q == KIND_READ) begin
                fkey_d = rkey_q;
                fpay_d = rpay_q;
              end
            end else begin
              prev_d = cur_q;
              cur_d  = rnxt_c;
              step_d = step_q + 1'b1;
            end
          end
        endcase
      end
      OP_FIX: begin
        wr_en   = 1'b1;
        wr_addr = AW'(prev_q);
        wr_data = cur_q;
      end
      OP_LINK_A: begin
        if (kind_q == KIND_REMOVE) begin
          if (prev_q == Nil) head_d = succ_q;
          else begin
            wr_en   = 1'b1;
            wr_addr = AW'(prev_q);
            wr_data = succ_q;
          end
        end else begin
          wr_en   = 1'b1;
          wr_addr = AW'(cur_q);
          wr_data = free_q;
        end
      end
      OP_LINK_B: begin
        if (kind_q == KIND_REMOVE) begin
          wr_en   = 1'b1;
          wr_addr = AW'(cur_q);
          wr_data = free_q;
          free_d  = cur_q;
          count_d = count_q - 1'b1;
          rem_d   = IW'(1);
        end else begin
          wr_en   = 1'b1;
          kp_en   = 1'b1;
          wr_addr = AW'(free_q);
          free_d  = fnext_q;
          count_d = count_q + 1'b1;
          if (no_walk) begin
            wr_data = head_q;
            head_d  = free_q;
          end else begin
            wr_data = succ_q;
          end
        end
      end
      default: ;
    endcase
  end

  // Node store read port.
  assign rd_en   = (cmd_i.op == OP_READ_CUR) || (cmd_i.op == OP_POP_READ);
  assign rd_addr = (cmd_i.op == OP_POP_READ) ? AW'(free_q) : AW'(cur_q);
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rkey_q <= key_mem[rd_addr];
      rpay_q <= pay_mem[rd_addr];
      rnxt_q <= nxt_mem[rd_addr];
    end
  end

  // Node store write port.
  always_ff @(posedge clk_i) begin
    if (wr_en) nxt_mem[wr_addr] <= wr_data;
    if (kp_en) begin
      key_mem[wr_addr] <= key_q;
      pay_mem[wr_addr] <= pay_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q  <= '0;
      head_q  <= Nil;
      free_q  <= '0;
      count_q <= '0;
      kind_q  <= '0;
      pos_q   <= '0;
      key_q   <= '0;
      pay_q   <= '0;
      cur_q   <= Nil;
      prev_q  <= Nil;
      step_q  <= '0;
      succ_q  <= Nil;
      fnext_q <= Nil;
      rem_q   <= '0;
      st_q    <= ST_OK;
      fkey_q  <= '0;
      fpay_q  <= '0;
      end_q   <= 1'b0;
    end else begin
      if (cmd_i.op == OP_INIT_STEP) init_q <= init_q + 1'b1;
      if (cmd_i.op == OP_LOAD) begin
        kind_q <= kind_i;
        pos_q  <= position_i;
        key_q  <= item_key_i;
        pay_q  <= item_payload_i;
      end
      if (cmd_i.op == OP_EVAL) end_q <= ev_done;
      head_q  <= head_d;
      free_q  <= free_d;
      count_q <= count_d;
      cur_q   <= cur_d;
      prev_q  <= prev_d;
      step_q  <= step_d;
      succ_q  <= succ_d;
      fnext_q <= fnext_d;
      rem_q   <= rem_d;
      st_q    <= st_d;
      fkey_q  <= fkey_d;
      fpay_q  <= fpay_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_FINISH) begin
      status_o        <= st_q;
      found_key_o     <= fkey_q;
      found_payload_o <= fpay_q;
      length_o        <= 8'(count_q);
      removed_count_o <= 8'(rem_q);
    end
  end

endmodule

@@ rtl/cursor_linked_list_engine_unit.sv @@
// Cursor linked-list engine: an ordered list kept as linked nodes in a node
// store, with unused nodes chained on a free list.
// Input channel: in_valid_i / in_stall_o carry one request beat (kind,
// position, key, payload). Output channel: out_valid_o / out_stall_i carry
// one result beat per request (status, found element, length, removed count).
// A beat moves when valid is high and stall is low.
// Requests are handled one at a time; a request settled by counts and list
// pointers alone goes from the decide state straight to done. A walk reads
// each visited node and then evaluates it. An insert or append first pops a
// free node; one at the head then writes only link B, while remove and any
// other insert or append ends with link A and link B. Delete adds a fix step
// per removed node that follows a kept node. The node store has a single read
// port. The next request can be accepted while the result is on the output.
// After reset the block chains all nodes on the free list, one node per
// cycle, with in_stall_o high.
// A result waiting under out_stall_i holds its payload steady; the next
// request is still taken and processed, and its result waits until the
// output register is free.
module cursor_linked_list_engine_unit
  import cll_pkg::*;
#(
  parameter int unsigned Capacity = CapacityDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         kind_i,
  input  logic [7:0]         position_i,
  input  logic signed [31:0] item_key_i,
  input  logic [31:0]        item_payload_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] found_key_o,
  output logic [31:0]        found_payload_o,
  output logic [7:0]         length_o,
  output logic [7:0]         removed_count_o
);

  cmd_t cmd;
  sts_t sts;

  cll_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cll_dp #(
    .Capacity (Capacity)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .kind_i          (kind_i),
    .position_i      (position_i),
    .item_key_i      (item_key_i),
    .item_payload_i  (item_payload_i),
    .status_o        (status_o),
    .found_key_o     (found_key_o),
    .found_payload_o (found_payload_o),
    .length_o        (length_o),
    .removed_count_o (removed_count_o)
  );

endmodule

@@ test/cursor_linked_list_engine_unit_test.sv @@
`timescale 1ns / 100ps

module cursor_linked_list_engine_unit_test;
  import cll_pkg::*;

  localparam int Cap = 128;
  localparam int Nil = Cap;
  localparam int WatchdogLimit = 20000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  position;
    logic [31:0] key;
    logic [31:0] payload;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_key;
    logic [31:0] found_payload;
    logic [7:0]  length;
    logic [7:0]  removed;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] kind_i = '0;
  logic [7:0] position_i = '0;
  logic signed [31:0] item_key_i = '0;
  logic [31:0] item_payload_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] status_o;
  logic signed [31:0] found_key_o;
  logic [31:0] found_payload_o;
  logic [7:0] length_o;
  logic [7:0] removed_count_o;

  cursor_linked_list_engine_unit dut (.*);

  // Shadow list state.
  logic [31:0] list_key [Cap];
  logic [31:0] list_payload [Cap];
  int unsigned list_link [Cap];
  int unsigned list_head;
  int unsigned free_top;
  int unsigned list_len;

  request_t pending_requests [$];
  answer_t awaited_answers [$];
  int mismatch_count = 0;
  int accepted_requests = 0;
  int checked_answers = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  bit stimulus_done = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_phase = 0;
  int kind_seen [8];

  function automatic int unsigned follow(int unsigned i);
    if (i >= Cap) return Nil;
    return (list_link[i] < Cap) ? list_link[i] : Nil;
  endfunction

  function automatic int unsigned walk_to(int unsigned p);
    int unsigned cur;
    cur = (list_head < Cap) ? list_head : Nil;
    for (int unsigned s = 1; s < p && cur != Nil && s < Cap + 1; s++) cur = follow(cur);
    return cur;
  endfunction

  function automatic void release_node(int unsigned n);
    if (n >= Cap) return;
    list_link[n] = free_top;
    free_top = n;
  endfunction

  function automatic answer_t apply_request(request_t r);
    answer_t a;
    int unsigned n, prev, cur, nxt, pos;
    a = '0;
    a.status = ST_OK;
    pos = r.position;
    case (r.kind)
      KIND_APPEND, KIND_INSERT: begin
        if (list_len >= Cap) a.status = ST_FULL;
        else if (r.kind == KIND_INSERT && (pos < 1 || pos > list_len + 1)) a.status = ST_RANGE;
        else if (free_top >= Cap) a.status = ST_FULL;
        else begin
          n = free_top;
          free_top = follow(n);
          list_key[n] = r.key;
          list_payload[n] = r.payload;
          list_link[n] = Nil;
          if (r.kind == KIND_APPEND) pos = list_len + 1;
          if (pos == 1 || list_head >= Cap) begin
            list_link[n] = (list_head < Cap) ? list_head : Nil;
            list_head = n;
          end else begin
            prev = walk_to(pos - 1);
            if (prev == Nil) begin
              list_link[n] = list_head;
              list_head = n;
            end else begin
              list_link[n] = follow(prev);
              list_link[prev] = n;
            end
          end
          list_len++;
        end
      end
      KIND_REMOVE: begin
        if (list_len == 0) a.status = ST_EMPTY;
        else if (pos < 1 || pos > list_len) a.status = ST_RANGE;
        else begin
          n = Nil;
          if (pos == 1) begin
            n = (list_head < Cap) ? list_head : Nil;
            if (n == Nil) a.status = ST_EMPTY;
            else list_head = follow(n);
          end else begin
            prev = walk_to(pos - 1);
            n = follow(prev);
            if (n == Nil) a.status = ST_RANGE;
            else list_link[prev] = follow(n);
          end
          if (a.status == ST_OK) begin
            release_node(n);
            list_len--;
            a.removed = 1;
          end
        end
      end
      KIND_DELETE: begin
        prev = Nil;
        cur = (list_head < Cap) ? list_head : Nil;
        for (int unsigned s = 0; cur != Nil && s < Cap; s++) begin
          nxt = follow(cur);
          if (list_key[cur] == r.key) begin
            if (prev == Nil) list_head = nxt;
            else list_link[prev] = nxt;
            release_node(cur);
            if (list_len > 0) list_len--;
            a.removed++;
          end else begin
            prev = cur;
          end
          cur = nxt;
        end
        if (a.removed == 0) a.status = ST_EMPTY;
      end
      KIND_READ: begin
        if (list_len == 0) a.status = ST_EMPTY;
        else if (pos < 1 || pos > list_len) a.status = ST_RANGE;
        else begin
          n = walk_to(pos);
          if (n == Nil) a.status = ST_RANGE;
          else begin
            a.found_key = list_key[n];
            a.found_payload = list_payload[n];
          end
        end
      end
      KIND_SEARCH: begin
        a.status = ST_EMPTY;
        cur = (list_head < Cap) ? list_head : Nil;
        for (int unsigned s = 0; cur != Nil && s < list_len && s < Cap; s++) begin
          if (list_key[cur] == r.key) begin
            a.status = ST_OK;
            a.found_key = list_key[cur];
            a.found_payload = list_payload[cur];
            break;
          end
          cur = follow(cur);
        end
      end
      default: a.status = ST_RANGE;
    endcase
    a.length = list_len[7:0];
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on answer %0d: %s got %0h want %0h", checked_answers, what, got, want);
    mismatch_count++;
  endtask

  function automatic request_t make_request(logic [2:0] k, int p, logic [31:0] key,
                                            logic [31:0] pay);
    request_t r;
    r.kind = k;
    r.position = p[7:0];
    r.key = key;
    r.payload = pay;
    return r;
  endfunction

  // Keys come from a small pool so that deletes and searches hit often.
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return 32'hffff_ffff;
      default: return $urandom_range(0, 11);
    endcase
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Sender: bursts of random length with random gaps.
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      accepted_requests++;
      kind_seen[kind_i]++;
      awaited_answers.push_back(apply_request(make_request(kind_i, int'(position_i),
                                                           item_key_i, item_payload_i)));
    end
    if (!in_valid_i || !in_stall_o) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (!hold_off && pending_requests.size() > 0 && rst_ni) begin
        request_t r;
        r = pending_requests.pop_front();
        in_valid_i <= 1'b1;
        kind_i <= r.kind;
        position_i <= r.position;
        item_key_i <= r.key;
        item_payload_i <= r.payload;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 20);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver and checker.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      answer_t want;
      if (awaited_answers.size() == 0) begin
        report_mismatch("unexpected beat", 32'h0, 32'h0);
      end else begin
        want = awaited_answers.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", 32'(status_o), 32'(want.status));
        if (found_key_o !== want.found_key)
          report_mismatch("found_key", found_key_o, want.found_key);
        if (found_payload_o !== want.found_payload)
          report_mismatch("found_payload", found_payload_o, want.found_payload);
        if (length_o !== want.length)
          report_mismatch("length", 32'(length_o), 32'(want.length));
        if (removed_count_o !== want.removed)
          report_mismatch("removed_count", 32'(removed_count_o), 32'(want.removed));
      end
      checked_answers++;
    end
    stall_phase <= (stall_phase + 1) % 97;
    if (stall_phase < 40) out_stall_i <= 1'b0;
    else if (stall_phase < 70) out_stall_i <= ($urandom_range(0, 3) == 0);
    else out_stall_i <= ($urandom_range(0, 1) == 0);
  end

  // Watchdog on cycles where no beat moves; covers the clearing pass and long walks.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired with %0d answers outstanding", awaited_answers.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int len_guess;
    logic [2:0] k;
    for (int i = 0; i < Cap; i++) begin
      list_key[i] = '0;
      list_payload[i] = '0;
      list_link[i] = i + 1;
    end
    list_head = Nil;
    free_top = 0;
    list_len = 0;

    // Directed: empty-list cases, extremes of keys and positions, bad kinds.
    pending_requests.push_back(make_request(KIND_REMOVE, 1, 0, 0));
    pending_requests.push_back(make_request(KIND_READ, 1, 0, 0));
    pending_requests.push_back(make_request(KIND_DELETE, 0, 5, 0));
    pending_requests.push_back(make_request(KIND_SEARCH, 0, 5, 0));
    pending_requests.push_back(make_request(KIND_INSERT, 0, 1, 1));
    pending_requests.push_back(make_request(KIND_INSERT, 2, 1, 1));
    pending_requests.push_back(make_request(KIND_INSERT, 1, 32'h8000_0000, 32'hffff_ffff));
    pending_requests.push_back(make_request(KIND_APPEND, 255, 32'h7fff_ffff, 0));
    pending_requests.push_back(make_request(KIND_INSERT, 3, 32'hffff_ffff, 32'h5555_aaaa));
    pending_requests.push_back(make_request(KIND_INSERT, 2, 32'h7fff_ffff, 32'haaaa_5555));
    pending_requests.push_back(make_request(KIND_READ, 0, 0, 0));
    pending_requests.push_back(make_request(KIND_READ, 5, 0, 0));
    pending_requests.push_back(make_request(KIND_READ, 4, 0, 0));
    pending_requests.push_back(make_request(KIND_SEARCH, 0, 32'h7fff_ffff, 0));
    pending_requests.push_back(make_request(KIND_DELETE, 0, 32'h7fff_ffff, 0));
    pending_requests.push_back(make_request(KIND_REMOVE, 0, 0, 0));
    pending_requests.push_back(make_request(KIND_REMOVE, 3, 0, 0));
    pending_requests.push_back(make_request(KIND_REMOVE, 2, 0, 0));
    pending_requests.push_back(make_request(3'd6, 1, 0, 0));
    pending_requests.push_back(make_request(3'd7, 1, 0, 0));
    pending_requests.push_back(make_request(KIND_REMOVE, 1, 0, 0));

    // Stimulus waits for the directed part to drain completely, then holds the sender off.
    wait (pending_requests.size() == 0 && !in_valid_i && awaited_answers.size() == 0);
    hold_off = 1'b1;
    repeat (50) @(posedge clk_i);
    hold_off = 1'b0;

    // Random: phases that fill toward full and drain toward empty.
    len_guess = 0;
    for (int i = 0; i < 1430; i++) begin
      bit grow;
      grow = ((i / 300) % 2 == 0);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: k = grow ? KIND_APPEND : KIND_REMOVE;
        6, 7, 8: k = grow ? KIND_INSERT : KIND_DELETE;
        9, 10, 11: k = KIND_READ;
        12, 13: k = KIND_SEARCH;
        14: k = KIND_DELETE;
        15: k = KIND_INSERT;
        16: k = KIND_REMOVE;
        17: k = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(6, 7)) : KIND_APPEND;
        default: k = 3'($urandom_range(0, 5));
      endcase
      pending_requests.push_back(make_request(k,
        ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 130),
        pick_key(), $urandom()));
    end

    stimulus_done = 1'b1;
    wait (pending_requests.size() == 0 && !in_valid_i && awaited_answers.size() == 0);
    repeat (500) @(posedge clk_i);
    $display("%0d requests accepted, %0d answers checked; appends %0d, inserts %0d,",
             accepted_requests, checked_answers, kind_seen[0], kind_seen[1]);
    $display("removes %0d, deletes %0d, reads %0d, searches %0d, unused kinds %0d",
             kind_seen[2], kind_seen[3], kind_seen[4], kind_seen[5],
             kind_seen[6] + kind_seen[7]);
    if (mismatch_count == 0 && awaited_answers.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
